FILE: sv/yuyv422_to_planar420_unit_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef YUYV422_TO_PLANAR420_UNIT_ASSERT_SVH
`define YUYV422_TO_PLANAR420_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Y2P_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define Y2P_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/y2p420_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package y2p420_pkg;

    localparam int DIM_W      = 12;
    localparam int ADDR_W     = 23;
    localparam int SAMPLE_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(176);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(144);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    typedef enum logic [1:0] {
        BEAT_Y0 = 2'd0,
        BEAT_Y1 = 2'd1,
        BEAT_C  = 2'd2
    } beat_t;

    typedef struct packed {
        logic                start_of_frame;
        logic [SAMPLE_W-1:0] luma_first;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] luma_second;
        logic [SAMPLE_W-1:0] chroma_red;
    } in_item_t;

    typedef struct packed {
        plane_t              plane;
        logic [ADDR_W-1:0]   byte_address;
        logic [SAMPLE_W-1:0] byte_value;
        logic                last;
    } out_item_t;

endpackage

`default_nettype wire

FILE: sv/yuyv422_to_planar420_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | ports                       | moves
// ---------+-----------------------------+----------------------------------------
// input    | s_valid s_ready s_data      | one YUYV group (two pixels) per item
// result   | m_valid m_ready m_data      | one byte write per item, three per group
// config   | cfg_we cfg_index cfg_wdata  | frame_width (0), frame_height (1)
//
// One group yields three result items: first luma, second luma, then the
// U (even row) or V (odd row) chroma byte, flagged last. One byte write per cycle
// goes out while m_ready is high; the next group loads as the chroma beat is taken.
// The three-stage pipe (position, multiply, address/serialize) takes input items
// every cycle while it has room; a group's first write is registered after stages
// A and B. Reset is synchronous, active low: counters zero, registers to 176 x 144;
// a stall on m_ready backs up the pipe stage by stage and nothing is dropped.

`include "yuyv422_to_planar420_unit_assert.svh"

module yuyv422_to_planar420_unit
    import y2p420_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Counter widths: pair column below MAX_WIDTH/2, row below MAX_HEIGHT.
    localparam int CW      = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int CW_RW   = (CW > RW) ? CW : RW;
    localparam int CMP_W   = ((CW_RW > DIM_W) ? CW_RW : DIM_W) + 1;
    localparam int DIM_MAX = (1 << DIM_W) - 2;
    localparam int W_CAP_I = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : (MAX_WIDTH & ~1);
    localparam int H_CAP_I = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : (MAX_HEIGHT & ~1);
    localparam logic [DIM_W-1:0] W_CAP = DIM_W'(W_CAP_I);
    localparam logic [DIM_W-1:0] H_CAP = DIM_W'(H_CAP_I);

    // Clear the low bit, then clamp into [2, cap].
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                 input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] v;
        v = {raw[DIM_W-1:1], 1'b0};
        if (v < DIM_W'(2)) v = DIM_W'(2);
        if (v > cap) v = cap;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and derived frame geometry
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]   frame_height_reg, frame_height_next;
    logic [DIM_W-1:0]   w_eff, h_eff, half_w;
    logic [2*DIM_W-1:0] luma_full;
    logic [2*DIM_W-1:0] luma_full_reg;
    logic [2*DIM_W:0]   v_full;
    logic [ADDR_W-1:0]  u_base_reg, v_base_reg;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_eff     = eff_dim(frame_width_reg, W_CAP);
    assign h_eff     = eff_dim(frame_height_reg, H_CAP);
    assign half_w    = {1'b0, w_eff[DIM_W-1:1]};
    assign luma_full = w_eff * h_eff;
    // V plane starts a quarter luma size after the U plane
    assign v_full    = {1'b0, luma_full_reg} + {3'b000, luma_full_reg[2*DIM_W-1:2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Plane bases go via luma_full_reg to u_base_reg and v_base_reg; the user writes
    // config only while idle, well ahead of the next item's address stage (not enforced).
    always_ff @(posedge aclk) begin
        luma_full_reg <= luma_full;
        u_base_reg    <= ADDR_W'(luma_full_reg);
        v_base_reg    <= ADDR_W'(v_full);
    end

    // ------------------------------------------------------------------
    // Pipe handshake: D (serializer) <- B (products) <- A (position)
    // ------------------------------------------------------------------
    logic  a_valid_reg, b_valid_reg, m_valid_reg;
    beat_t beat_reg, beat_next;
    logic  d_free, ld_d, b_free, a_to_b, a_free, s_take;

    assign d_free  = !m_valid_reg || (m_ready && beat_reg == BEAT_C);
    assign ld_d    = b_valid_reg && d_free;
    assign b_free  = !b_valid_reg || ld_d;
    assign a_to_b  = a_valid_reg && b_free;
    assign a_free  = !a_valid_reg || a_to_b;
    assign s_ready = a_free;
    assign s_take  = s_valid && a_free;

    // ------------------------------------------------------------------
    // Position counters: resolve this group's column and row, then advance
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CMP_W-1:0] hw_c, h_c, col0, row0, col1, row1, pos_row, col_inc, row_inc;
    logic [CMP_W-1:0] adv_col, adv_row;

    always_comb begin
        hw_c = CMP_W'(half_w);
        h_c  = CMP_W'(h_eff);
        // start of frame clears the position before this group
        col0 = s_data.start_of_frame ? '0 : CMP_W'(col_reg);
        row0 = s_data.start_of_frame ? '0 : CMP_W'(row_reg);
        // stale column after a width change: take it as the next row's start
        col1 = (col0 >= hw_c) ? '0 : col0;
        row1 = (col0 >= hw_c) ? row0 + CMP_W'(1) : row0;
        pos_row = (row1 >= h_c) ? '0 : row1;
        // advance past this group, wrapping at row and frame end
        col_inc = col1 + CMP_W'(1);
        row_inc = pos_row + CMP_W'(1);
        if (col_inc >= hw_c) begin
            adv_col = '0;
            adv_row = (row_inc >= h_c) ? '0 : row_inc;
        end else begin
            adv_col = col_inc;
            adv_row = pos_row;
        end
        col_next = s_take ? CW'(adv_col) : col_reg;
        row_next = s_take ? RW'(adv_row) : row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register with resolved position
    // ------------------------------------------------------------------
    in_item_t      a_item_reg;
    logic [CW-1:0] a_col_reg;
    logic [RW-1:0] a_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_item_reg <= s_data;
            a_col_reg  <= CW'(col1);
            a_row_reg  <= RW'(pos_row);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: row products for luma and chroma addresses
    // ------------------------------------------------------------------
    logic [RW+DIM_W-1:0] prod_y_full, prod_c_full;
    in_item_t            b_item_reg;
    logic [CW-1:0]       b_col_reg;
    logic                b_row_odd_reg;
    logic [ADDR_W-1:0]   b_prod_y_reg, b_prod_c_reg;

    assign prod_y_full = a_row_reg * w_eff;
    assign prod_c_full = (a_row_reg >> 1) * half_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_to_b) begin
            b_item_reg    <= a_item_reg;
            b_col_reg     <= a_col_reg;
            b_row_odd_reg <= a_row_reg[0];
            b_prod_y_reg  <= ADDR_W'(prod_y_full);
            b_prod_c_reg  <= ADDR_W'(prod_c_full);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: final addresses and three-beat serializer on the result port
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]   y_addr, c_addr;
    logic [ADDR_W-1:0]   d_y_addr_reg, d_y_addr_next;
    logic [ADDR_W-1:0]   d_c_addr_reg, d_c_addr_next;
    logic [SAMPLE_W-1:0] d_luma2_reg, d_luma2_next;
    logic [SAMPLE_W-1:0] d_chroma_reg, d_chroma_next;
    plane_t              d_plane_reg, d_plane_next;
    out_item_t           m_data_reg, m_data_next;
    logic                m_valid_next;

    assign y_addr = b_prod_y_reg + ADDR_W'({b_col_reg, 1'b0});
    assign c_addr = (b_row_odd_reg ? v_base_reg : u_base_reg) + b_prod_c_reg
                    + ADDR_W'(b_col_reg);

    always_comb begin
        d_y_addr_next = d_y_addr_reg;
        d_c_addr_next = d_c_addr_reg;
        d_luma2_next  = d_luma2_reg;
        d_chroma_next = d_chroma_reg;
        d_plane_next  = d_plane_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        beat_next     = beat_reg;
        if (ld_d) begin
            // load a fresh group and show its first luma write at once
            d_y_addr_next = y_addr;
            d_c_addr_next = c_addr;
            d_luma2_next  = b_item_reg.luma_second;
            d_chroma_next = b_row_odd_reg ? b_item_reg.chroma_red
                                          : b_item_reg.chroma_blue;
            d_plane_next  = b_row_odd_reg ? PLANE_V : PLANE_U;
            m_data_next.plane        = PLANE_Y;
            m_data_next.byte_address = y_addr;
            m_data_next.byte_value   = b_item_reg.luma_first;
            m_data_next.last         = 1'b0;
            m_valid_next  = 1'b1;
            beat_next     = BEAT_Y0;
        end else if (m_valid_reg && m_ready) begin
            case (beat_reg)
                BEAT_Y0: begin
                    m_data_next.plane        = PLANE_Y;
                    m_data_next.byte_address = d_y_addr_reg + ADDR_W'(1);
                    m_data_next.byte_value   = d_luma2_reg;
                    m_data_next.last         = 1'b0;
                    beat_next = BEAT_Y1;
                end
                BEAT_Y1: begin
                    m_data_next.plane        = d_plane_reg;
                    m_data_next.byte_address = d_c_addr_reg;
                    m_data_next.byte_value   = d_chroma_reg;
                    m_data_next.last         = 1'b1;
                    beat_next = BEAT_C;
                end
                default: begin
                    // chroma taken and nothing waiting: drop valid
                    m_valid_next = 1'b0;
                    beat_next    = BEAT_Y0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            beat_reg    <= BEAT_Y0;
        end else begin
            m_valid_reg <= m_valid_next;
            beat_reg    <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_y_addr_reg <= d_y_addr_next;
        d_c_addr_reg <= d_c_addr_next;
        d_luma2_reg  <= d_luma2_next;
        d_chroma_reg <= d_chroma_next;
        d_plane_reg  <= d_plane_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `Y2P_ASSERT_SAME(a_last_is_chroma, aclk, aresetn,
        m_valid_reg && m_data_reg.last,
        m_data_reg.plane != PLANE_Y && beat_reg == BEAT_C,
        "last flag on a write that is not the chroma beat")
    `Y2P_ASSERT_NEXT(a_luma_pair_adjacent, aclk, aresetn,
        m_valid_reg && m_ready && beat_reg == BEAT_Y0,
        m_data_reg.byte_address == ADDR_W'($past(m_data_reg.byte_address) + 1'b1),
        "second luma address does not follow the first")
    `Y2P_ASSERT_NEXT(a_col_within_row, aclk, aresetn,
        s_valid && s_ready,
        CMP_W'(col_reg) < CMP_W'(half_w),
        "pair column left the row after an accepted item")
    `Y2P_ASSERT_NEXT(a_stage_a_holds, aclk, aresetn,
        a_valid_reg && !a_to_b,
        a_valid_reg && $stable(a_item_reg) && $stable(a_col_reg) && $stable(a_row_reg),
        "stalled position stage lost or changed its item")

endmodule

`default_nettype wire

FILE: tb/tb_yuyv422_to_planar420_unit.sv
`timescale 1ns / 1ps

module tb_yuyv422_to_planar420_unit;
    import y2p420_pkg::*;

    // Hard stop for the whole run, in clock cycles.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // Number of random groups to send after the directed part.
    localparam int unsigned RANDOM_GROUPS = 210;
    // Extra cycles to hold after the last write, so stray items show up.
    localparam int unsigned TAIL_CYCLES   = 20;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Local copy of the converter state: raw registers and position counters.
    // The counters carry a guard bit so an increment past the row end is seen.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [10:0]      pair_col;
    logic [11:0]      row_num;

    // Byte writes still to come from the converter, oldest first.
    out_item_t   expected_writes[$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned random_sent;
    bit          tx_gaps_on;
    bit          rx_stall_on;
    int unsigned rx_stall_left;

    yuyv422_to_planar420_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Clear the low bit, then clamp into [2, limit].
    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] raw,
                                                  input int unsigned limit);
        int unsigned v;
        v = {raw[DIM_W-1:1], 1'b0};
        if (v < 2) v = 2;
        if (v > limit) v = limit & ~32'd1;
        if (v < 2) v = 2;
        return v;
    endfunction

    // Advance the local position and queue the three byte writes of one group:
    // first luma, second luma, then U on even rows or V on odd rows.
    function automatic void predict_group(input in_item_t grp);
        int unsigned w;
        int unsigned h;
        int unsigned half_w;
        int unsigned luma_size;
        int unsigned row_base;
        int unsigned chroma_addr;
        out_item_t   wr;
        w         = effective_dim(width_reg, MAX_WIDTH_DEF);
        h         = effective_dim(height_reg, MAX_HEIGHT_DEF);
        half_w    = w / 2;
        luma_size = w * h;

        if (grp.start_of_frame) begin
            pair_col = '0;
            row_num  = '0;
        end
        // A column or row left over from a larger geometry wraps first.
        if (pair_col >= half_w) begin
            pair_col = '0;
            row_num  = row_num + 1'b1;
        end
        if (row_num >= h) row_num = '0;

        row_base = row_num * w + 2 * pair_col;
        wr.plane        = PLANE_Y;
        wr.byte_address = ADDR_W'(row_base);
        wr.byte_value   = grp.luma_first;
        wr.last         = 1'b0;
        expected_writes.push_back(wr);
        wr.byte_address = ADDR_W'(row_base + 1);
        wr.byte_value   = grp.luma_second;
        expected_writes.push_back(wr);

        chroma_addr = luma_size + (row_num / 2) * half_w + pair_col;
        if (row_num[0] == 1'b0) begin
            wr.plane        = PLANE_U;
            wr.byte_address = ADDR_W'(chroma_addr);
            wr.byte_value   = grp.chroma_blue;
        end else begin
            wr.plane        = PLANE_V;
            wr.byte_address = ADDR_W'(chroma_addr + luma_size / 4);
            wr.byte_value   = grp.chroma_red;
        end
        wr.last = 1'b1;
        expected_writes.push_back(wr);

        pair_col = pair_col + 1'b1;
        if (pair_col >= half_w) begin
            pair_col = '0;
            row_num  = row_num + 1'b1;
            if (row_num >= h) row_num = '0;
        end
    endfunction

    // Mostly no wait, sometimes a short one, rarely a long stretch.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register value: usually a small frame, sometimes an edge value, sometimes any.
    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned small_max);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 7))
                    0: return DIM_W'(0);
                    1: return DIM_W'(1);
                    2: return DIM_W'(2);
                    3: return DIM_W'(3);
                    4: return DIM_W'(2048);
                    5: return DIM_W'(2049);
                    6: return DIM_W'(4094);
                    default: return DIM_W'(4095);
                endcase
            end
            1: return DIM_W'($urandom_range(0, 4095));
            default: return DIM_W'($urandom_range(0, small_max));
        endcase
    endfunction

    function automatic in_item_t group_of(input bit sof, input logic [7:0] y0,
                                          input logic [7:0] u, input logic [7:0] y1,
                                          input logic [7:0] v);
        in_item_t grp;
        grp.start_of_frame = sof;
        grp.luma_first     = y0;
        grp.chroma_blue    = u;
        grp.luma_second    = y1;
        grp.chroma_red     = v;
        return grp;
    endfunction

    task automatic report_error(input string what, input int unsigned got,
                                input int unsigned want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Entered and left just after a falling edge. Hold valid and the group
    // until the converter takes it; leave valid high for a back-to-back item.
    task automatic send_group(input in_item_t grp);
        s_data  <= grp;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_group(grp);
        @(negedge aclk);
    endtask

    // Drop valid for a random gap, unless gaps are off for this stretch.
    task automatic idle_tx();
        int unsigned gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drop valid and hold off until every queued write has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // One write strobe, then a quiet gap with cfg_we low so strobes never merge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        if (idx == REG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Reset geometry 176 x 144: sample extremes, then a mid-row start of frame.
    task automatic test_reset_geometry();
        send_group(group_of(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        idle_tx();
        send_group(group_of(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        idle_tx();
        send_group(group_of(1'b0, 8'hA5, 8'h5A, 8'h3C, 8'hC3));
        idle_tx();
        send_group(group_of(1'b1, 8'h01, 8'h80, 8'hFE, 8'h7F));
        idle_tx();
    endtask

    // Zero registers give a 2 x 2 frame: every group is a row, so U and V alternate
    // and the frame wraps every second group.
    task automatic test_tiny_frame();
        int k;
        set_geometry(DIM_W'(0), DIM_W'(0));
        for (k = 0; k < 5; k++) begin
            send_group(group_of(k == 0, 8'(k * 17), 8'(8'hF0 - k), 8'(k * 29 + 3),
                                8'(k + 8'h10)));
            idle_tx();
        end
    endtask

    // Oversized and odd register values: clamp to the maximum, clear the low bit.
    task automatic test_clamped_geometry();
        int k;
        set_geometry(DIM_W'(4095), DIM_W'(2049));
        for (k = 0; k < 3; k++) begin
            send_group(group_of(k == 0, 8'hFF, 8'h00, 8'h00, 8'hFF));
            idle_tx();
        end
        set_geometry(DIM_W'(7), DIM_W'(3));
        for (k = 0; k < 4; k++) begin
            send_group(group_of(k == 0, 8'(k), 8'(k + 1), 8'(k + 2), 8'(k + 3)));
            idle_tx();
        end
    endtask

    // Shrink the geometry mid-frame: a stale column moves to the next row,
    // and a stale row folds back to the top.
    task automatic test_stale_position();
        int k;
        set_geometry(DIM_W'(16), DIM_W'(8));
        for (k = 0; k < 4; k++) begin
            send_group(group_of(k == 0, 8'h11, 8'h22, 8'h33, 8'h44));
            idle_tx();
        end
        wait_idle();
        write_reg(REG_FRAME_WIDTH, DIM_W'(4));
        send_group(group_of(1'b0, 8'h55, 8'h66, 8'h77, 8'h88));
        set_geometry(DIM_W'(2), DIM_W'(2));
        for (k = 0; k < 2; k++) begin
            send_group(group_of(1'b0, 8'h99, 8'hAA, 8'hBB, 8'hCC));
            idle_tx();
        end
    endtask

    // Random phases: pick a geometry, stream groups with random samples and
    // occasional start of frame. Some phases pause mid-stream until drained.
    task automatic test_random_frames();
        int unsigned phase;
        int          n;
        int          k;
        int          pause_at;
        bit          sof;
        phase = 0;
        while (random_sent < RANDOM_GROUPS) begin
            set_geometry(pick_dim(40), pick_dim(12));
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(8, 40);
            pause_at = (phase == 0 || $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 2) : -1;
            for (k = 0; k < n; k++) begin
                sof = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0);
                send_group(group_of(sof, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
                random_sent++;
                if (k == pause_at) wait_idle();
                else idle_tx();
            end
            phase++;
        end
    endtask

    // Result side: drive ready at the falling edge, with random stall stretches.
    initial begin
        m_ready       = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_stall_left != 0) begin
                m_ready <= 1'b0;
                rx_stall_left--;
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                rx_stall_left = pick_gap();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted write against the oldest one queued.
    always @(posedge aclk) begin : check_writes
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_writes.size() == 0) begin
                report_error("write with none pending, address", m_data.byte_address, 0);
            end else begin
                want = expected_writes.pop_front();
                if (m_data.plane !== want.plane)
                    report_error("plane", m_data.plane, want.plane);
                if (m_data.byte_address !== want.byte_address)
                    report_error("byte_address", m_data.byte_address, want.byte_address);
                if (m_data.byte_value !== want.byte_value)
                    report_error("byte_value", m_data.byte_value, want.byte_value);
                if (m_data.last !== want.last)
                    report_error("last", m_data.last, want.last);
            end
        end
    end

    // Stop a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        error_count = 0;
        random_sent = 0;
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        width_reg   = FRAME_WIDTH_RST;
        height_reg  = FRAME_HEIGHT_RST;
        pair_col    = '0;
        row_num     = '0;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_geometry();
        test_tiny_frame();
        test_clamped_geometry();
        test_stale_position();
        test_random_frames();

        // Drain, then hold for TAIL_CYCLES so stray writes get caught.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_writes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: yuyv422_to_planar420_unit.f
+incdir+sv
sv/y2p420_pkg.sv
sv/yuyv422_to_planar420_unit.sv
tb/tb_yuyv422_to_planar420_unit.sv
